/* rtl/flep_pkg.sv */
// Package for the file list entry parser: parse phase codes and character constants.
// Has no dependencies; used by flep_core and file_list_entry_parser.
package flep_pkg;

    localparam int PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_TYPE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_QUOTE   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_NAME    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ESC     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_NAMEEND = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SIZE    = 3'd5;
    localparam logic [PHASE_W-1:0] PH_TIME    = 3'd6;
    localparam logic [PHASE_W-1:0] PH_EXTRA   = 3'd7;

    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam logic KIND_NAME  = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    // Number of results one input byte produces.
    typedef logic [1:0] push_cnt_t;

endpackage

/* rtl/flep_core.sv */
// Parser state machine of the file list entry parser: takes one byte per transfer
// and produces up to two packed result records. Depends on flep_pkg.
module flep_core #(
    parameter int VALUE_WIDTH = 64,
    parameter int REC_W       = 12 + 2 * VALUE_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  logic [7:0]            in_byte,
    output flep_pkg::push_cnt_t   push_cnt,
    output logic [REC_W-1:0]      rec0,
    output logic [REC_W-1:0]      rec1
);

    localparam int VW = VALUE_WIDTH;

    logic [flep_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic                         dir_reg, dir_next;
    logic                         err_reg, err_next;
    logic [VW-1:0]                size_reg, size_next;
    logic [VW-1:0]                time_reg, time_next;
    logic                         started_reg, started_next;
    logic                         stopped_reg, stopped_next;

    logic [VW-1:0] num_acc_in, num_acc_out;
    logic          num_started_in, num_started_out;
    logic          num_stopped_in, num_stopped_out;
    logic          is_digit;
    logic [REC_W-1:0] r0, r1;
    flep_pkg::push_cnt_t n;

    function automatic logic [REC_W-1:0] name_rec(input logic [7:0] b);
        logic [REC_W-1:0] r;
        r = '0;
        r[0] = flep_pkg::KIND_NAME;
        r[8:1] = b;
        return r;
    endfunction

    function automatic logic [REC_W-1:0] entry_rec(
        input logic dir, input logic err, input logic [VW-1:0] sz, input logic [VW-1:0] tm
    );
        logic [REC_W-1:0] r;
        r = '0;
        r[0] = flep_pkg::KIND_ENTRY;
        r[9] = dir;
        r[9+VW:10] = dir ? '0 : sz;
        r[9+2*VW:10+VW] = dir ? '0 : tm;
        r[10+2*VW] = err;
        return r;
    endfunction

    // Decimal accumulation shared by the size and time fields.
    always_comb begin
        if (phase_reg == flep_pkg::PH_NAMEEND) begin
            num_acc_in     = '0;
            num_started_in = 1'b0;
            num_stopped_in = 1'b0;
        end else begin
            num_acc_in     = (phase_reg == flep_pkg::PH_TIME) ? time_reg : size_reg;
            num_started_in = started_reg;
            num_stopped_in = stopped_reg;
        end
        is_digit        = in_byte inside {[8'h30:8'h39]};
        num_acc_out     = num_acc_in;
        num_started_out = num_started_in;
        num_stopped_out = num_stopped_in;
        if (!num_stopped_in && !(!num_started_in && in_byte == flep_pkg::CH_SPACE)) begin
            if (is_digit) begin
                num_acc_out = (num_acc_in << 3) + (num_acc_in << 1)
                              + {{(VW-4){1'b0}}, in_byte[3:0]};
                num_started_out = 1'b1;
            end else begin
                num_stopped_out = 1'b1;
            end
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        dir_next     = dir_reg;
        err_next     = err_reg;
        size_next    = size_reg;
        time_next    = time_reg;
        started_next = started_reg;
        stopped_next = stopped_reg;
        r0 = '0;
        r1 = '0;
        n  = 2'd0;
        case (phase_reg)
            flep_pkg::PH_TYPE: begin
                dir_next   = (in_byte == flep_pkg::CH_D);
                err_next   = (in_byte != flep_pkg::CH_F) && (in_byte != flep_pkg::CH_D);
                phase_next = flep_pkg::PH_QUOTE;
            end
            flep_pkg::PH_QUOTE: begin
                phase_next = flep_pkg::PH_NAME;
            end
            flep_pkg::PH_NAME: begin
                if (in_byte == flep_pkg::CH_QUOTE) begin
                    phase_next = flep_pkg::PH_NAMEEND;
                end else if (in_byte == flep_pkg::CH_BSLASH) begin
                    phase_next = flep_pkg::PH_ESC;
                end else begin
                    r0 = name_rec(in_byte);
                    n  = 2'd1;
                end
            end
            flep_pkg::PH_ESC: begin
                if (in_byte != flep_pkg::CH_QUOTE && in_byte != flep_pkg::CH_BSLASH) begin
                    r0 = name_rec(flep_pkg::CH_BSLASH);
                    r1 = name_rec(in_byte);
                    n  = 2'd2;
                end else begin
                    r0 = name_rec(in_byte);
                    n  = 2'd1;
                end
                phase_next = flep_pkg::PH_NAME;
            end
            flep_pkg::PH_NAMEEND: begin
                if (in_byte == flep_pkg::CH_QUOTE) begin
                    r0 = name_rec(flep_pkg::CH_QUOTE);
                    r1 = name_rec(flep_pkg::CH_QUOTE);
                    n  = 2'd2;
                    phase_next = flep_pkg::PH_NAME;
                end else if (dir_reg) begin
                    if (in_byte == flep_pkg::CH_NL) begin
                        r0 = entry_rec(dir_reg, err_reg, size_reg, time_reg);
                        n  = 2'd1;
                        phase_next   = flep_pkg::PH_TYPE;
                        dir_next     = 1'b0;
                        err_next     = 1'b0;
                        size_next    = '0;
                        time_next    = '0;
                        started_next = 1'b0;
                        stopped_next = 1'b0;
                    end else begin
                        phase_next = flep_pkg::PH_EXTRA;
                    end
                end else begin
                    size_next    = num_acc_out;
                    started_next = num_started_out;
                    stopped_next = num_stopped_out;
                    phase_next   = flep_pkg::PH_SIZE;
                end
            end
            flep_pkg::PH_SIZE: begin
                if (in_byte == flep_pkg::CH_SPACE) begin
                    time_next    = '0;
                    started_next = 1'b0;
                    stopped_next = 1'b0;
                    phase_next   = flep_pkg::PH_TIME;
                end else begin
                    size_next    = num_acc_out;
                    started_next = num_started_out;
                    stopped_next = num_stopped_out;
                end
            end
            flep_pkg::PH_TIME: begin
                if (in_byte == flep_pkg::CH_NL) begin
                    r0 = entry_rec(dir_reg, err_reg, size_reg, time_reg);
                    n  = 2'd1;
                    phase_next   = flep_pkg::PH_TYPE;
                    dir_next     = 1'b0;
                    err_next     = 1'b0;
                    size_next    = '0;
                    time_next    = '0;
                    started_next = 1'b0;
                    stopped_next = 1'b0;
                end else if (in_byte == flep_pkg::CH_HASH) begin
                    phase_next = flep_pkg::PH_EXTRA;
                end else begin
                    time_next    = num_acc_out;
                    started_next = num_started_out;
                    stopped_next = num_stopped_out;
                end
            end
            default: begin
                if (in_byte == flep_pkg::CH_NL) begin
                    r0 = entry_rec(dir_reg, err_reg, size_reg, time_reg);
                    n  = 2'd1;
                    phase_next   = flep_pkg::PH_TYPE;
                    dir_next     = 1'b0;
                    err_next     = 1'b0;
                    size_next    = '0;
                    time_next    = '0;
                    started_next = 1'b0;
                    stopped_next = 1'b0;
                end
            end
        endcase
        // The final result of a transfer carries the last flag.
        if (n == 2'd1) begin
            r0[11+2*VW] = 1'b1;
        end else if (n == 2'd2) begin
            r1[11+2*VW] = 1'b1;
        end
    end

    assign push_cnt = in_accept ? n : 2'd0;
    assign rec0     = r0;
    assign rec1     = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= flep_pkg::PH_TYPE;
            dir_reg     <= 1'b0;
            err_reg     <= 1'b0;
            size_reg    <= '0;
            time_reg    <= '0;
            started_reg <= 1'b0;
            stopped_reg <= 1'b0;
        end else if (in_accept) begin
            phase_reg   <= phase_next;
            dir_reg     <= dir_next;
            err_reg     <= err_next;
            size_reg    <= size_next;
            time_reg    <= time_next;
            started_reg <= started_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

/* rtl/file_list_entry_parser.sv */
// Top level of the file list entry parser: parser core and a four-entry result queue.
// Depends on flep_pkg and flep_core.
//
//  Channel | Direction | tdata                                         | tuser    | tlast
//  s_      | in        | in_byte                                       | -        | -
//  m_      | out       | name_byte, is_dir, file_size, mod_time, error | out_kind | last
//
// One input byte is taken every cycle while the result queue has room for two results.
// A byte's results are registered in the queue before they reach the m_ side.
// A byte that yields two results is presented on the output as two successive transfers.
// Reset is synchronous and returns the parser to expecting a type byte with an empty queue.
// Stalls on the m_ side fill the queue and then hold off s_tready.
module file_list_entry_parser #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,  // in_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // name_byte, is_dir, file_size, mod_time, type_error, zero padding
    output logic [((10 + 2 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                  m_tuser,  // out_kind
    output logic                  m_tlast   // last
);

    localparam int VW      = VALUE_WIDTH;
    localparam int REC_W   = 12 + 2 * VW;
    localparam int DATA_W  = ((10 + 2 * VW + 7) / 8) * 8;
    localparam int Q_DEPTH = 4;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = PTR_W + 1;

    logic                 in_accept;
    flep_pkg::push_cnt_t  push_cnt;
    logic [REC_W-1:0]     rec0, rec1;

    logic [REC_W-1:0]     q_mem [Q_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 pop;
    logic [REC_W-1:0]     head;

    assign s_tready  = (count_reg <= CNT_W'(Q_DEPTH - 2));
    assign in_accept = s_tvalid && s_tready;

    flep_core #(
        .VALUE_WIDTH (VW),
        .REC_W       (REC_W)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .push_cnt  (push_cnt),
        .rec0      (rec0),
        .rec1      (rec1)
    );

    assign pop  = m_tvalid && m_tready;
    assign head = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q_mem[wr_ptr_reg] <= rec0;
        end
        if (push_cnt == 2'd2) begin
            q_mem[wr_ptr_reg + PTR_W'(1)] <= rec1;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tuser  = head[0];
    assign m_tlast  = head[11+2*VW];
    assign m_tdata  = DATA_W'(head[10+2*VW:1]);

endmodule
